// ===== design/rfse_pkg.sv =====
// Shared types and constants of the reverse-Polish floating-point stack evaluator.
package rfse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [10:0] EXP_ONES  = 11'h7FF;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_DUP  = 3'd5,
      OP_SWAP = 3'd6,
      OP_DROP = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2
   } cell_cmd_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] value;
      logic        end_of_call;
   } req_type;

   typedef struct packed {
      logic [63:0]        top_value;
      logic [DEPTH_W-1:0] depth;
      status_type         status;
      logic               call_failed;
   } rsp_type;

endpackage

// ===== design/rfse_cell.sv =====
// One stack entry that loads from its upper or lower neighbor.
module rfse_cell
   import rfse_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic [63:0]  up_data,
   input  logic [63:0]  down_data,
   output logic [63:0]  data
);

   logic [63:0] data_ff;
   logic [63:0] data_in;

   always_comb begin
      unique case (cmd)
         CELL_PUSH: data_in = up_data;
         CELL_POP:  data_in = down_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/rfse_fpu.sv =====
// Multi-cycle double-precision add, subtract, multiply and divide unit.
module rfse_fpu
   import rfse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  op_type      op,
   input  logic [63:0] deep,
   input  logic [63:0] top,
   output logic        done,
   output logic [63:0] result
);

   typedef enum logic [8:0] {
      FS_IDLE    = 9'b000000001,
      FS_PRENORM = 9'b000000010,
      FS_MUL     = 9'b000000100,
      FS_DIV     = 9'b000001000,
      FS_ALIGN   = 9'b000010000,
      FS_ADD     = 9'b000100000,
      FS_NORM    = 9'b001000000,
      FS_DENORM  = 9'b010000000,
      FS_ROUND   = 9'b100000000
   } fstate_type;

   fstate_type         state_ff, state_in;
   op_type             op_ff, op_in;
   logic               sa_ff, sa_in, sb_ff, sb_in, s_ff, s_in;
   logic signed [12:0] ea_ff, ea_in, eb_ff, eb_in, e_ff, e_in;
   logic [52:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [127:0]       m_ff, m_in, yal_ff, yal_in;
   logic               st_ff, st_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [53:0]        prod_ff, prod_in;
   logic [54:0]        rem_ff, rem_in;
   logic [63:0]        res_ff, res_in;
   logic               done_ff, done_in;

   logic [10:0]        xa_raw, xb_raw;
   logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic               sbe, sx;
   logic signed [12:0] ea_un, eb_un;
   logic               special;
   logic [63:0]        special_val;

   logic [26:0]        pp_a, pp_b;
   logic [1:0]         pp_prev;
   logic [127:0]       pp_shifted;
   logic               q_bit;
   logic [54:0]        rem_diff;
   logic               a_big;
   logic [52:0]        mx, my;
   logic signed [12:0] ex, diff;
   logic [127:0]       y_full, y_sh;
   logic               y_lost;
   logic               rnd_up;
   logic [53:0]        rnd_sum;
   logic signed [12:0] rnd_exp;

   // unpack and special operands
   always_comb begin
      xa_raw = deep[62:52];
      xb_raw = top[62:52];
      nan_a  = (xa_raw == EXP_ONES) && (deep[51:0] != '0);
      nan_b  = (xb_raw == EXP_ONES) && (top[51:0] != '0);
      inf_a  = (xa_raw == EXP_ONES) && (deep[51:0] == '0);
      inf_b  = (xb_raw == EXP_ONES) && (top[51:0] == '0);
      zero_a = (deep[62:0] == '0);
      zero_b = (top[62:0] == '0);
      sbe    = top[63] ^ (op == OP_SUB);
      sx     = deep[63] ^ top[63];
      ea_un  = (xa_raw == '0) ? 13'sd1 : signed'({2'b00, xa_raw});
      eb_un  = (xb_raw == '0) ? 13'sd1 : signed'({2'b00, xb_raw});
      special     = 1'b1;
      special_val = CANON_NAN;
      if (!(nan_a || nan_b)) begin
         unique case (op) inside
            OP_ADD, OP_SUB: begin
               if (inf_a && inf_b) begin
                  special_val = (deep[63] != sbe) ? CANON_NAN : {deep[63], EXP_ONES, 52'b0};
               end else if (inf_a) begin
                  special_val = {deep[63], EXP_ONES, 52'b0};
               end else if (inf_b) begin
                  special_val = {sbe, EXP_ONES, 52'b0};
               end else if (zero_a && zero_b) begin
                  special_val = {deep[63] & sbe, 63'b0};
               end else if (zero_b) begin
                  special_val = deep;
               end else if (zero_a) begin
                  special_val = {sbe, top[62:0]};
               end else begin
                  special = 1'b0;
               end
            end
            OP_MUL: begin
               if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                  special_val = CANON_NAN;
               end else if (inf_a || inf_b) begin
                  special_val = {sx, EXP_ONES, 52'b0};
               end else if (zero_a || zero_b) begin
                  special_val = {sx, 63'b0};
               end else begin
                  special = 1'b0;
               end
            end
            default: begin
               if ((inf_a && inf_b) || (zero_a && zero_b)) begin
                  special_val = CANON_NAN;
               end else if (inf_a || zero_b) begin
                  special_val = {sx, EXP_ONES, 52'b0};
               end else if (inf_b || zero_a) begin
                  special_val = {sx, 63'b0};
               end else begin
                  special = 1'b0;
               end
            end
         endcase
      end
   end

   // datapath helpers
   always_comb begin
      pp_a    = cnt_ff[1] ? ma_ff[52:26] : {1'b0, ma_ff[25:0]};
      pp_b    = cnt_ff[0] ? mb_ff[52:26] : {1'b0, mb_ff[25:0]};
      prod_in = pp_a * pp_b;
      pp_prev = cnt_ff[1:0] - 2'd1;
      case (pp_prev)
         2'd0:    pp_shifted = {52'b0, prod_ff, 22'b0};
         2'd3:    pp_shifted = {prod_ff, 74'b0};
         default: pp_shifted = {26'b0, prod_ff, 48'b0};
      endcase

      q_bit    = rem_ff >= {2'b00, mb_ff};
      rem_diff = q_bit ? (rem_ff - {2'b00, mb_ff}) : rem_ff;

      a_big  = (ea_ff > eb_ff) || ((ea_ff == eb_ff) && (ma_ff >= mb_ff));
      mx     = a_big ? ma_ff : mb_ff;
      my     = a_big ? mb_ff : ma_ff;
      ex     = a_big ? ea_ff : eb_ff;
      diff   = a_big ? (ea_ff - eb_ff) : (eb_ff - ea_ff);
      y_full = {1'b0, my, 74'b0};
      if (diff > 13'sd127) begin
         y_sh   = '0;
         y_lost = 1'b1;
      end else begin
         y_sh   = y_full >> diff[6:0];
         y_lost = (y_sh << diff[6:0]) != y_full;
      end

      rnd_up  = m_ff[74] & ((|m_ff[73:0]) | st_ff | m_ff[75]);
      rnd_sum = {1'b0, m_ff[127:75]} + {53'b0, rnd_up};
      if (rnd_sum[53]) begin
         rnd_exp = e_ff + 13'sd1;
      end else if (rnd_sum[52]) begin
         rnd_exp = e_ff;
      end else begin
         rnd_exp = 13'sd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      s_in     = s_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      e_in     = e_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      m_in     = m_ff;
      yal_in   = yal_ff;
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            if (start) begin
               op_in = op;
               sa_in = deep[63];
               sb_in = sbe;
               ea_in = ea_un;
               eb_in = eb_un;
               ma_in = {xa_raw != '0, deep[51:0]};
               mb_in = {xb_raw != '0, top[51:0]};
               if (special) begin
                  res_in  = special_val;
                  done_in = 1'b1;
               end else begin
                  state_in = FS_PRENORM;
               end
            end
         end
         FS_PRENORM: begin
            if (!ma_ff[52]) begin
               if (ma_ff[52:45] == '0) begin
                  ma_in = ma_ff << 8;
                  ea_in = ea_ff - 13'sd8;
               end else begin
                  ma_in = ma_ff << 1;
                  ea_in = ea_ff - 13'sd1;
               end
            end
            if (!mb_ff[52]) begin
               if (mb_ff[52:45] == '0) begin
                  mb_in = mb_ff << 8;
                  eb_in = eb_ff - 13'sd8;
               end else begin
                  mb_in = mb_ff << 1;
                  eb_in = eb_ff - 13'sd1;
               end
            end
            if (ma_ff[52] && mb_ff[52]) begin
               cnt_in = '0;
               st_in  = 1'b0;
               s_in   = sa_ff ^ sb_ff;
               unique case (op_ff) inside
                  OP_MUL: begin
                     m_in     = '0;
                     e_in     = ea_ff + eb_ff - 13'sd1022;
                     state_in = FS_MUL;
                  end
                  OP_DIV: begin
                     rem_in   = {2'b00, ma_ff};
                     e_in     = ea_ff - eb_ff + 13'sd1023;
                     state_in = FS_DIV;
                  end
                  default: state_in = FS_ALIGN;
               endcase
            end
         end
         FS_MUL: begin
            if (cnt_ff != 6'd0) begin
               m_in = m_ff + pp_shifted;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4) begin
               state_in = FS_NORM;
            end
         end
         FS_DIV: begin
            rem_in = {rem_diff[53:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               m_in     = {m_ff[54:0], q_bit, 72'b0};
               st_in    = rem_diff != '0;
               state_in = FS_NORM;
            end else begin
               m_in = {m_ff[126:0], q_bit};
            end
         end
         FS_ALIGN: begin
            m_in     = {1'b0, mx, 74'b0};
            yal_in   = y_sh | {127'b0, y_lost};
            e_in     = ex + 13'sd1;
            s_in     = a_big ? sa_ff : sb_ff;
            state_in = FS_ADD;
         end
         FS_ADD: begin
            m_in     = (sa_ff != sb_ff) ? (m_ff - yal_ff) : (m_ff + yal_ff);
            st_in    = 1'b0;
            state_in = FS_NORM;
         end
         FS_NORM: begin
            if (m_ff == '0) begin
               res_in   = '0;
               done_in  = 1'b1;
               state_in = FS_IDLE;
            end else if (m_ff[127]) begin
               state_in = FS_DENORM;
            end else if (m_ff[127:120] == '0) begin
               m_in = m_ff << 8;
               e_in = e_ff - 13'sd8;
            end else begin
               m_in = m_ff << 1;
               e_in = e_ff - 13'sd1;
            end
         end
         FS_DENORM: begin
            if (e_ff >= 13'sd1) begin
               state_in = FS_ROUND;
            end else if (m_ff == '0) begin
               e_in = 13'sd1;
            end else if (e_ff <= -13'sd15) begin
               m_in  = m_ff >> 16;
               st_in = st_ff | (|m_ff[15:0]);
               e_in  = e_ff + 13'sd16;
            end else begin
               m_in  = m_ff >> 1;
               st_in = st_ff | m_ff[0];
               e_in  = e_ff + 13'sd1;
            end
         end
         FS_ROUND: begin
            if (rnd_exp >= 13'sd2047) begin
               res_in = {s_ff, EXP_ONES, 52'b0};
            end else begin
               res_in = {s_ff, rnd_exp[10:0], rnd_sum[51:0]};
            end
            done_in  = 1'b1;
            state_in = FS_IDLE;
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff   <= op_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      s_ff    <= s_in;
      ea_ff   <= ea_in;
      eb_ff   <= eb_in;
      e_ff    <= e_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      m_ff    <= m_in;
      yal_ff  <= yal_in;
      st_ff   <= st_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== design/rpn_float_stack_evaluator.sv =====
// Top level: reverse-Polish token evaluator over a chain of double-precision stack cells.
// Push, dup, swap, drop and short math ops post rsp in the cycle after accept; one token per
// cycle unless blocked. Math on special operands posts via FPU done_ff, then rsp_valid_ff;
// normal operands pass prenorm, mul, div or align and add, norm, denorm and round states
// (sequential FPU, 27x27 partial products, one quotient bit per cycle); subnormals add
// shifting. A math token or stalled rsp blocks input; reset empties stack, clears call error.
module rpn_float_stack_evaluator
   import rfse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               err_ff, err_in;
   logic               fail_ff, fail_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               busy_ff, busy_in;
   logic               eoc_ff;

   logic               accept;
   logic               fin;
   logic               eoc_sel;
   status_type         status_now;
   logic               fpu_start;
   logic               fpu_done;
   logic [63:0]        fpu_result;
   logic               is_full;

   cell_cmd_type       cmd0, cmd1, cmdr;
   logic [63:0]        head;
   cell_cmd_type       cell_cmd  [STACK_DEPTH];
   logic [63:0]        cell_data [STACK_DEPTH];
   logic [63:0]        up_data   [STACK_DEPTH];
   logic [63:0]        down_data [STACK_DEPTH];

   assign req_stall = busy_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign is_full   = depth_ff == DEPTH_W'(STACK_DEPTH);

   always_comb begin
      cmd0       = CELL_HOLD;
      cmd1       = CELL_HOLD;
      cmdr       = CELL_HOLD;
      head       = req_data.value;
      depth_in   = depth_ff;
      fin        = 1'b0;
      status_now = ST_OK;
      fpu_start  = 1'b0;
      busy_in    = busy_ff;
      eoc_sel    = eoc_ff;
      if (accept) begin
         eoc_sel = req_data.end_of_call;
         unique case (req_data.op) inside
            OP_PUSH: begin
               fin = 1'b1;
               if (is_full) begin
                  status_now = ST_OVER;
               end else begin
                  cmd0     = CELL_PUSH;
                  cmd1     = CELL_PUSH;
                  cmdr     = CELL_PUSH;
                  depth_in = depth_ff + DEPTH_W'(1);
               end
            end
            OP_DUP: begin
               fin  = 1'b1;
               head = cell_data[0];
               if (depth_ff == '0) begin
                  status_now = ST_UNDER;
               end else if (is_full) begin
                  status_now = ST_OVER;
               end else begin
                  cmd0     = CELL_PUSH;
                  cmd1     = CELL_PUSH;
                  cmdr     = CELL_PUSH;
                  depth_in = depth_ff + DEPTH_W'(1);
               end
            end
            OP_SWAP: begin
               fin  = 1'b1;
               head = cell_data[1];
               if (depth_ff < DEPTH_W'(2)) begin
                  status_now = ST_UNDER;
               end else begin
                  cmd0 = CELL_PUSH;
                  cmd1 = CELL_PUSH;
               end
            end
            OP_DROP: begin
               fin = 1'b1;
               if (depth_ff == '0) begin
                  status_now = ST_UNDER;
               end else begin
                  cmd0     = CELL_POP;
                  cmd1     = CELL_POP;
                  cmdr     = CELL_POP;
                  depth_in = depth_ff - DEPTH_W'(1);
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (depth_ff < DEPTH_W'(2)) begin
                  fin        = 1'b1;
                  status_now = ST_UNDER;
                  depth_in   = '0;
               end else begin
                  fpu_start = 1'b1;
                  busy_in   = 1'b1;
               end
            end
            default: fin = 1'b0;
         endcase
      end else if (fpu_done) begin
         head     = fpu_result;
         cmd0     = CELL_PUSH;
         cmd1     = CELL_POP;
         cmdr     = CELL_POP;
         depth_in = depth_ff - DEPTH_W'(1);
         busy_in  = 1'b0;
         fin      = 1'b1;
      end
   end

   always_comb begin
      err_in       = err_ff;
      fail_in      = fail_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fin) begin
         status_in    = status_now;
         fail_in      = err_ff | (status_now != ST_OK);
         err_in       = eoc_sel ? 1'b0 : (err_ff | (status_now != ST_OK));
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= 1'b0;
         fail_ff      <= 1'b0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         fail_ff      <= fail_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
      end
      if (accept) begin
         eoc_ff <= req_data.end_of_call;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign up_data[i]  = head;
         assign cell_cmd[i] = cmd0;
      end else begin : g_body
         assign up_data[i]  = cell_data[i-1];
         assign cell_cmd[i] = (i == 1) ? cmd1 : cmdr;
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign down_data[i] = '0;
      end else begin : g_link
         assign down_data[i] = cell_data[i+1];
      end
      rfse_cell u_cell (
         .clock     (clock),
         .cmd       (cell_cmd[i]),
         .up_data   (up_data[i]),
         .down_data (down_data[i]),
         .data      (cell_data[i])
      );
   end

   rfse_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (fpu_start),
      .op     (req_data.op),
      .deep   (cell_data[1]),
      .top    (cell_data[0]),
      .done   (fpu_done),
      .result (fpu_result)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.top_value    = (depth_ff != '0) ? cell_data[0] : 64'b0;
   assign rsp_data.depth        = depth_ff;
   assign rsp_data.status       = status_ff;
   assign rsp_data.call_failed  = fail_ff;

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("response pending while FPU busy");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack depth out of range");

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      fpu_done |-> busy_ff)
      else $error("FPU finished with no token in flight");

   a_math_starts: assert property (@(posedge clock) disable iff (reset)
      fpu_start |=> busy_ff && !rsp_valid_ff)
      else $error("math token did not hold the block busy");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_OVER) |-> is_full)
      else $error("overflow reported on a stack that is not full");

endmodule

// ===== test/rfse_checker.sv =====
// Checker for the stack evaluator: predicts each response from accepted tokens and compares.
module rfse_checker
   import rfse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0] stack_mem [STACK_DEPTH];
   int          stack_size;
   logic        sticky_err;
   rsp_type     expected_q [$];

   function automatic logic is_nan(logic [63:0] v);
      return v[62:52] == EXP_ONES && v[51:0] != 52'd0;
   endfunction

   function automatic logic [63:0] fp_math(op_type op, logic [63:0] deep, logic [63:0] top);
      real         x, y, r;
      logic [63:0] res;
      x = $bitstoreal(deep);
      y = $bitstoreal(top);
      if (op == OP_DIV && top[62:0] == 63'd0 && !is_nan(deep)) begin
         if (deep[62:0] == 63'd0) return CANON_NAN;
         return {deep[63] ^ top[63], EXP_ONES, 52'd0};
      end
      case (op)
         OP_ADD:  r = x + y;
         OP_SUB:  r = x - y;
         OP_MUL:  r = x * y;
         default: r = x / y;
      endcase
      res = $realtobits(r);
      if (is_nan(res)) res = CANON_NAN;
      return res;
   endfunction

   task automatic evaluate_token(req_type t);
      status_type st;
      rsp_type    e;
      logic [63:0] tmp;
      st = ST_OK;
      case (t.op) inside
         OP_PUSH: begin
            if (stack_size >= STACK_DEPTH) st = ST_OVER;
            else begin
               stack_mem[stack_size] = t.value;
               stack_size++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (stack_size < 2) begin
               stack_size = 0;
               st = ST_UNDER;
            end else begin
               tmp = fp_math(t.op, stack_mem[stack_size-2], stack_mem[stack_size-1]);
               stack_size--;
               stack_mem[stack_size-1] = tmp;
            end
         end
         OP_DUP: begin
            if (stack_size < 1) st = ST_UNDER;
            else if (stack_size >= STACK_DEPTH) st = ST_OVER;
            else begin
               stack_mem[stack_size] = stack_mem[stack_size-1];
               stack_size++;
            end
         end
         OP_SWAP: begin
            if (stack_size < 2) st = ST_UNDER;
            else begin
               tmp = stack_mem[stack_size-1];
               stack_mem[stack_size-1] = stack_mem[stack_size-2];
               stack_mem[stack_size-2] = tmp;
            end
         end
         default: begin
            if (stack_size < 1) st = ST_UNDER;
            else stack_size--;
         end
      endcase
      if (st != ST_OK) sticky_err = 1'b1;
      e.top_value   = stack_size != 0 ? stack_mem[stack_size-1] : 64'd0;
      e.depth       = DEPTH_W'(stack_size);
      e.status      = st;
      e.call_failed = sticky_err;
      expected_q.push_back(e);
      if (t.end_of_call) sticky_err = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         stack_size = 0;
         sticky_err = 1'b0;
         expected_q.delete();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) evaluate_token(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.top_value !== e.top_value) begin
                  $display("%0t: top_value expected %h actual %h", $time,
                           e.top_value, rsp_data.top_value);
                  mismatches++;
               end
               if (rsp_data.depth !== e.depth) begin
                  $display("%0t: depth expected %0d actual %0d", $time, e.depth,
                           rsp_data.depth);
                  mismatches++;
               end
               if (rsp_data.status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.call_failed !== e.call_failed) begin
                  $display("%0t: call_failed expected %0b actual %0b", $time,
                           e.call_failed, rsp_data.call_failed);
                  mismatches++;
               end
            end
         end
      end
      pending = expected_q.size();
   end
endmodule

// ===== test/rpn_float_stack_evaluator_tb.sv =====
// Testbench top: drives token stimulus with random idling and reports the verdict.
module rpn_float_stack_evaluator_tb;
   import rfse_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      mismatches;
   int      pending;
   int      gen_depth;
   logic    long_hold;
   logic    burst_mode;

   rpn_float_stack_evaluator uut (.*);

   rfse_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int gap_len();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand_double();
      int s;
      s = $urandom_range(0, 9);
      case (s)
         0, 1: return {$urandom, $urandom};
         2: return $realtobits($itor($signed($urandom_range(0, 200)) - 100));
         3: begin
            case ($urandom_range(0, 5))
               0: return 64'd0;
               1: return 64'h8000_0000_0000_0000;
               2: return 64'h7FF0_0000_0000_0000;
               3: return 64'hFFF0_0000_0000_0000;
               4: return 64'h0000_0000_0000_0001;
               default: return 64'h7FEF_FFFF_FFFF_FFFF;
            endcase
         end
         default: return {1'($urandom), 11'(1023 - 20 + $urandom_range(0, 40)),
                          20'($urandom), $urandom};
      endcase
   endfunction

   task automatic send_token(op_type op, logic [63:0] v, logic eoc);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data.op      <= op;
      req_data.value   <= v;
      req_data.end_of_call <= eoc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (op) inside
         OP_PUSH: if (gen_depth < STACK_DEPTH) gen_depth++;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: gen_depth = gen_depth < 2 ? 0 : gen_depth - 1;
         OP_DUP: if (gen_depth > 0 && gen_depth < STACK_DEPTH) gen_depth++;
         OP_DROP: if (gen_depth > 0) gen_depth--;
         default: ;
      endcase
   endtask

   // receiver side
   initial begin
      int hold;
      logic long_seen;
      rsp_stall = 1'b0;
      hold = 0;
      long_seen = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold && !long_seen) begin
            long_seen = 1'b1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (burst_mode) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 25) begin
            hold = $urandom_range(0, 99) < 90 ? $urandom_range(0, 2) : $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int r;
      op_type op;
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      gen_depth = 0;
      long_hold = 1'b0;
      burst_mode = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_token(OP_ADD, 64'd0, 1'b0);
      send_token(OP_DUP, 64'd0, 1'b0);
      send_token(OP_DROP, 64'd0, 1'b0);
      send_token(OP_SWAP, 64'd0, 1'b1);
      send_token(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_token(OP_SWAP, 64'd0, 1'b0);
      send_token(OP_PUSH, 64'h0000_0000_0000_0000, 1'b0);
      send_token(OP_DIV, 64'd0, 1'b0);
      send_token(OP_PUSH, $realtobits(3.5), 1'b0);
      send_token(OP_PUSH, 64'h8000_0000_0000_0000, 1'b0);
      send_token(OP_DIV, 64'd0, 1'b0);
      send_token(OP_PUSH, 64'd0, 1'b0);
      send_token(OP_PUSH, 64'd0, 1'b0);
      send_token(OP_DIV, 64'd0, 1'b0);
      send_token(OP_PUSH, $realtobits(-2.25), 1'b0);
      send_token(OP_SUB, 64'd0, 1'b0);
      send_token(OP_PUSH, 64'h7FF0_0000_0000_0000, 1'b0);
      send_token(OP_PUSH, 64'hFFF0_0000_0000_0000, 1'b0);
      send_token(OP_ADD, 64'd0, 1'b0);
      send_token(OP_PUSH, $realtobits(1.5), 1'b0);
      send_token(OP_MUL, 64'd0, 1'b1);
      while (gen_depth < STACK_DEPTH) send_token(OP_DUP, 64'd0, 1'b0);
      send_token(OP_PUSH, $realtobits(7.0), 1'b0);
      send_token(OP_DUP, 64'd0, 1'b1);

      // random: mostly well-formed expressions
      for (int i = 0; i < 1600; i++) begin
         if (i % 150 == 0) burst_mode = $urandom_range(0, 3) == 0;
         if (i == 300) long_hold = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 8) op = op_type'($urandom_range(0, 7));
         else if (gen_depth < 2 || (gen_depth < 6 && r < 55)) op = OP_PUSH;
         else if (r < 40) op = op_type'($urandom_range(1, 4));
         else if (r < 60 && gen_depth < 40) op = OP_PUSH;
         else if (r < 70) op = OP_SWAP;
         else if (r < 78) op = OP_DUP;
         else if (r < 86) op = OP_DROP;
         else op = op_type'($urandom_range(1, 4));
         send_token(op, rand_double(), $urandom_range(0, 9) == 0);
      end
      req_valid <= 1'b0;
      burst_mode = 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== rpn_float_stack_evaluator.f =====
design/rfse_pkg.sv
design/rfse_cell.sv
design/rfse_fpu.sv
design/rpn_float_stack_evaluator.sv
test/rfse_checker.sv
test/rpn_float_stack_evaluator_tb.sv
